// File: src/iwpm_pkg.sv
// Shared constants for the isolated white pixel marker.
`default_nettype none

package iwpm_pkg;

    localparam int PIXEL_W     = 8;
    localparam int ROW_W       = 12;
    localparam int OUT_COL_W   = 11;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 4;

    localparam logic [PIXEL_W-1:0] WHITE      = 8'd255;
    localparam logic [PIXEL_W-1:0] MARK_VALUE = 8'd125;

    // Smallest legal image dimension in either direction.
    localparam logic [CFG_DATA_W-1:0] MIN_DIM = 12'd3;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    // Window size and the most white pixels an isolated center may see.
    localparam int WIN_SIZE    = 9;
    localparam int WIN_CENTER  = 4;
    localparam int COUNT_W     = 4;
    localparam logic [COUNT_W-1:0] MAX_ISOLATED_WHITES = 4'd1;

endpackage

`default_nettype wire

// File: src/iwpm_intf.sv
// Valid/ready channel interfaces for pixels, results and register writes.
`default_nettype none

interface iwpm_pixel_if import iwpm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;
    logic               frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface iwpm_result_if import iwpm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ROW_W-1:0]     center_row;
    logic [OUT_COL_W-1:0] center_col;
    logic [PIXEL_W-1:0]   result_value;
    logic                 marked;

    modport source (output valid, output center_row, output center_col,
                    output result_value, output marked, input ready);
    modport sink   (input valid, input center_row, input center_col,
                    input result_value, input marked, output ready);
endinterface

interface iwpm_cfg_if import iwpm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/isolated_white_pixel_marker_top.sv
// Isolated white pixel marker: 3x3 window filter over a raster pixel stream.
`default_nettype none

// Pixels arrive in raster order, one item per cycle at full rate, and each
// pixel at row r >= 2 and column c >= 2 produces one result for the pixel at
// (r-1, c-1). That result is built from stage one and is loaded into the
// result register when stage one advances, where it waits for the sink until
// it is taken. A white center (255) whose eight neighbors are
// all non-white is reported as 125 and marked; every other center is reported
// unchanged. Border pixels produce no result. The accepted pixel is held in
// one stage beside the registered reads of the two line buffers (MAX_WIDTH
// bytes each), and that stage feeds the result register directly. A waiting
// result stalls the input only while the sink holds ready low. The line
// buffers need no clearing pass after reset. Register 0 sets the image width
// (clamped to 3..MAX_WIDTH), register 1 the height (at least 3); write them
// only while the block is idle. frame_start on an item restarts the row and
// column counters at that pixel.
module isolated_white_pixel_marker_top
    import iwpm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire           clk,
    input  wire           rst_n,
    iwpm_pixel_if.sink    pixels,
    iwpm_result_if.source results,
    iwpm_cfg_if.sink      cfg
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((WID_W > CFG_DATA_W) ? WID_W : CFG_DATA_W) + 1;
    localparam logic [CMP_W-1:0] MAX_WIDTH_C = CMP_W'(MAX_WIDTH);

    // Configuration registers
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    // Raster counters for the next item
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Stage one: accepted pixel with its line buffer reads
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_fwd_reg;
    logic [PIXEL_W-1:0] s1_fwd_top_reg;
    logic [PIXEL_W-1:0] s1_fwd_mid_reg;
    logic [PIXEL_W-1:0] rd_top_reg;
    logic [PIXEL_W-1:0] rd_mid_reg;

    logic [PIXEL_W-1:0] line_one_above [0:MAX_WIDTH-1];
    logic [PIXEL_W-1:0] line_two_above [0:MAX_WIDTH-1];

    logic [PIXEL_W-1:0] win_reg  [0:WIN_SIZE-1];
    logic [PIXEL_W-1:0] win_next [0:WIN_SIZE-1];

    // Result register
    logic                 out_valid_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [PIXEL_W-1:0]   out_value_reg;
    logic                 out_marked_reg;

    logic                 accept;
    logic                 s1_adv;
    logic [COL_W-1:0]     cur_col;
    logic [ROW_W-1:0]     cur_row;
    logic [CMP_W-1:0]     eff_width;
    logic [CFG_DATA_W-1:0] eff_height;
    logic                 col_wrap;
    logic                 row_wrap;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_next;
    logic [PIXEL_W-1:0]   s1_top;
    logic [PIXEL_W-1:0]   s1_mid;
    logic [WIN_SIZE-1:0]  white_flags;
    logic [COUNT_W-1:0]   white_count;
    logic                 is_marked;
    logic                 interior;
    logic [COL_W-1:0]     col_minus_one;
    logic [ROW_W-1:0]     row_minus_one;

    assign cfg.ready = 1'b1;

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign accept       = pixels.valid && pixels.ready;

    assign cur_col = pixels.frame_start ? '0 : col_reg;
    assign cur_row = pixels.frame_start ? '0 : row_reg;

    always_comb
    begin
        if (width_reg < MIN_DIM)
            eff_width = CMP_W'(MIN_DIM);
        else if (CMP_W'(width_reg) > MAX_WIDTH_C)
            eff_width = MAX_WIDTH_C;
        else
            eff_width = CMP_W'(width_reg);

        eff_height = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;

        col_wrap = (CMP_W'(cur_col) + CMP_W'(1)) >= eff_width;
        row_wrap = ({1'b0, cur_row} + 13'd1) >= {1'b0, eff_height};

        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : cur_row + ROW_W'(1);
        end
        else
        begin
            col_next = cur_col + COL_W'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                // The item ahead writes the same column at this edge, so the
                // memory read would miss its update.
                s1_fwd_reg   <= s1_adv && (s1_col_reg == cur_col);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= pixels.pixel_value;
            s1_col_reg     <= cur_col;
            s1_row_reg     <= cur_row;
            s1_fwd_top_reg <= s1_mid;
            s1_fwd_mid_reg <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_two_above[s1_col_reg] <= s1_mid;
        if (accept)
            rd_top_reg <= line_two_above[cur_col];
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_one_above[s1_col_reg] <= s1_pix_reg;
        if (accept)
            rd_mid_reg <= line_one_above[cur_col];
    end

    assign s1_top = s1_fwd_reg ? s1_fwd_top_reg : rd_top_reg;
    assign s1_mid = s1_fwd_reg ? s1_fwd_mid_reg : rd_mid_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k * 3]     = win_reg[k * 3 + 1];
            win_next[k * 3 + 1] = win_reg[k * 3 + 2];
        end
        win_next[2] = s1_top;
        win_next[5] = s1_mid;
        win_next[8] = s1_pix_reg;

        for (int k = 0; k < WIN_SIZE; k++)
            white_flags[k] = (win_next[k] == WHITE);
    end

    // The count includes the center itself, so an isolated white center
    // sees exactly one white pixel.
    assign white_count = COUNT_W'($countones(white_flags));
    assign is_marked   = white_flags[WIN_CENTER] && (white_count <= MAX_ISOLATED_WHITES);
    assign interior    = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2));

    assign col_minus_one = s1_col_reg - COL_W'(1);
    assign row_minus_one = s1_row_reg - ROW_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_SIZE; k++)
                win_reg[k] <= '0;
        end
        else if (s1_adv)
        begin
            for (int k = 0; k < WIN_SIZE; k++)
                win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= interior;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_row_reg    <= row_minus_one;
            out_col_reg    <= OUT_COL_W'(col_minus_one);
            out_value_reg  <= is_marked ? MARK_VALUE : win_next[WIN_CENTER];
            out_marked_reg <= is_marked;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.center_row   = out_row_reg;
    assign results.center_col   = out_col_reg;
    assign results.result_value = out_value_reg;
    assign results.marked       = out_marked_reg;

endmodule

`default_nettype wire
